@@ src/dqu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, item types and cell control shared by the queue
// top level and its storage cells.
// ----------------------------------------------------------------------------
package dqu_pkg;

	localparam int unsigned DEPTH_DEF      = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] push_data;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] pop_data;
		status_t     status;
		logic [6:0]  element_count;
	} rsp_item_t;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_ctl_t;

endpackage

@@ src/dqu_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One word of storage with its valid bit. Shifts toward the back on a front
// push, toward the front on a front pop, and loads or drops at the tail.
// ----------------------------------------------------------------------------
module dqu_cell #(
	parameter int unsigned DATA_WIDTH = dqu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dqu_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] new_word,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] right_word,
	input  logic                  right_valid,
	output logic [DATA_WIDTH-1:0] word,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] tap
);
	import dqu_pkg::*;

	logic [DATA_WIDTH-1:0] word_q;
	logic                  valid_q;
	logic                  is_tail;
	logic                  is_gap;

	assign is_tail = valid_q && !right_valid;
	assign is_gap  = !valid_q && left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_back && is_gap) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_back && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			word_q <= left_word;
		end else if (ctl.pop_front) begin
			word_q <= right_word;
		end else if (ctl.push_back && is_gap) begin
			word_q <= new_word;
		end
	end

	assign word  = word_q;
	assign valid = valid_q;
	assign tap   = is_tail ? word_q : '0;

endmodule

@@ src/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Fixed-depth deque of data words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel carries one command per item: push front, push back, pop
//   front or pop back, with the word to push. rsp channel returns one item
//   per command: the popped word (zero for pushes and refused pops), a
//   status (done, empty, full) and the element count after the command.
//   The response is registered, valid in the cycle after command accept. One
//   command is taken per cycle while cmd_stall is low; the rate is set by the
//   single response register, refilled in the same cycle it is drained.
//   Storage is DEPTH cells in a row; the front is always cell 0, a front push
//   or pop moves every cell one place at once, a back push fills the first
//   empty cell after the tail and a back pop clears the tail cell only.
//   Reset empties the queue at once; no clearing pass is needed.
//   While rsp_stall holds a waiting response, cmd_stall is raised and the
//   queue state holds.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
	parameter int unsigned DEPTH      = dqu_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = dqu_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  dqu_pkg::cmd_item_t cmd_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output dqu_pkg::rsp_item_t rsp_item
);
	import dqu_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_item_q;
	logic                  take;
	logic                  is_full;
	logic                  is_empty;
	logic                  is_push;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] new_word;
	logic [DATA_WIDTH-1:0] popped;
	logic [CW-1:0]         count_next;
	rsp_item_t             rsp_next;

	logic [DATA_WIDTH-1:0] words [DEPTH];
	logic [DEPTH-1:0]      valids;
	logic [DATA_WIDTH-1:0] taps [DEPTH];
	logic [DATA_WIDTH-1:0] tail_or [DEPTH+1];

	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign take      = cmd_valid && !cmd_stall;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign is_push   = (cmd_item.command == CMD_PUSH_FRONT) ||
	                   (cmd_item.command == CMD_PUSH_BACK);
	assign new_word  = DATA_WIDTH'(cmd_item.push_data);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] lw;
			logic                  lv;
			logic [DATA_WIDTH-1:0] rw;
			logic                  rv;
			if (i == 0) begin : g_head
				assign lw = new_word;
				assign lv = 1'b1;
			end else begin : g_mid
				assign lw = words[i-1];
				assign lv = valids[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign rw = '0;
				assign rv = 1'b0;
			end else begin : g_next
				assign rw = words[i+1];
				assign rv = valids[i+1];
			end
			dqu_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.new_word   (new_word),
				.left_word  (lw),
				.left_valid (lv),
				.right_word (rw),
				.right_valid(rv),
				.word       (words[i]),
				.valid      (valids[i]),
				.tap        (taps[i])
			);
			assign tail_or[i+1] = tail_or[i] | taps[i];
		end
	endgenerate

	assign tail_or[0] = '0;

	always_comb begin
		ctl        = '0;
		popped     = '0;
		count_next = count_q;
		rsp_next   = '0;
		case (cmd_item.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) begin
					rsp_next.status = ST_FULL;
				end else begin
					ctl.push_front  = (cmd_item.command == CMD_PUSH_FRONT);
					ctl.push_back   = (cmd_item.command == CMD_PUSH_BACK);
					count_next      = count_q + CW'(1);
					rsp_next.status = ST_DONE;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (is_empty) begin
					rsp_next.status = ST_EMPTY;
				end else begin
					ctl.pop_front   = (cmd_item.command == CMD_POP_FRONT);
					ctl.pop_back    = (cmd_item.command == CMD_POP_BACK);
					popped          = ctl.pop_front ? words[0] : tail_or[DEPTH];
					count_next      = count_q - CW'(1);
					rsp_next.status = ST_DONE;
				end
			end
			default: begin
				rsp_next.status = ST_DONE;
			end
		endcase
		if (!take) begin
			ctl = '0;
		end
		rsp_next.pop_data      = is_push ? 32'd0 : 32'(popped);
		rsp_next.element_count = 7'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_item_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule
